/* hdl/elsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsc_pkg
// Types and codes shared by the load segment checker and its range cells.
// ----------------------------------------------------------------------------
package elsc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USER_BASE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USER_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECL_COUNT    = 3'd4;

	// Result codes.
	localparam logic [3:0] ERR_OK          = 4'd0;
	localparam logic [3:0] ERR_SKIPPED     = 4'd1;
	localparam logic [3:0] ERR_FILE_SIZE   = 4'd2;
	localparam logic [3:0] ERR_FILE_OVF    = 4'd3;
	localparam logic [3:0] ERR_FILE_END    = 4'd4;
	localparam logic [3:0] ERR_MEM_OVF     = 4'd5;
	localparam logic [3:0] ERR_MEM_ZERO    = 4'd6;
	localparam logic [3:0] ERR_WINDOW      = 4'd7;
	localparam logic [3:0] ERR_ALIGN_POW2  = 4'd8;
	localparam logic [3:0] ERR_ALIGN_MOD   = 4'd9;
	localparam logic [3:0] ERR_WRITE_EXEC  = 4'd10;
	localparam logic [3:0] ERR_ROUND_OVF   = 4'd11;
	localparam logic [3:0] ERR_EMPTY       = 4'd12;
	localparam logic [3:0] ERR_OVERLAP     = 4'd13;
	localparam logic [3:0] ERR_TOO_MANY    = 4'd14;

	localparam logic [31:0] PT_LOAD = 32'd1;

	// A page-rounded mapping travelling down the row of range cells.
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [63:0] map_start;
		logic [63:0] map_end;
	} query_t;

endpackage

/* hdl/elf_load_segment_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_load_segment_checker_unit
// Checks ELF64 program headers and tracks the load mappings of one image.
// ----------------------------------------------------------------------------
// An accepted header passes the check states CHK1, CHK2 and CHK3; a load
// header that passes the field checks then walks as a query through the
// row of MAX_SEGMENTS range cells, one cell a cycle. One item is in work
// at a time; the next is taken the cycle after the result register is
// loaded, which a stalled result channel can hold off.
// Reset clears control state and configuration; stored ranges are read once written.
module elf_load_segment_checker_unit #(
	parameter int PAGE_SHIFT   = 12,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [elsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	// header channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    header_type,
	input  logic [31:0]                    header_flags,
	input  logic [63:0]                    offset_in_file,
	input  logic [63:0]                    virt_addr,
	input  logic [63:0]                    bytes_in_file,
	input  logic [63:0]                    bytes_in_memory,
	input  logic [63:0]                    align_value,
	input  logic                           last_header,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           is_load,
	output logic                           segment_ok,
	output logic [3:0]                     error_code,
	output logic [63:0]                    map_base,
	output logic [52:0]                    map_pages,
	output logic                           writable,
	output logic                           executable,
	output logic                           image_done,
	output logic                           image_ok,
	output logic                           entry_ok
);

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [63:0] PAGE_SIZE = 64'd1 << PAGE_SHIFT;
	localparam logic [63:0] PAGE_MASK = PAGE_SIZE - 64'd1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHK1 = 5'b00010,
		ST_CHK2 = 5'b00100,
		ST_CHK3 = 5'b01000,
		ST_WALK = 5'b10000
	} state_t;

	// Finishing is tracked apart from the walk states so that a stalled
	// result waits without disturbing them.
	state_t state_q;
	logic   done_q;

	// configuration registers
	logic [63:0] image_size_q;
	logic [63:0] entry_address_q;
	logic [63:0] user_base_q;
	logic [63:0] user_limit_q;
	logic [4:0]  decl_count_q;

	// image state
	logic [CNT_W-1:0] count_q;
	logic             failed_q;
	logic             found_q;

	// captured header
	logic        is_load_q;
	logic        wr_q;
	logic        ex_q;
	logic        last_q;
	logic [63:0] off_q;
	logic [63:0] va_q;
	logic [63:0] fsz_q;
	logic [63:0] msz_q;
	logic [63:0] al_q;

	// check stages
	logic [64:0] fend_q;
	logic [64:0] memend_q;
	logic        e_fsz_q, e_mzero_q, e_base_q, e_pow2_q, e_mod_q;
	logic        e_img_q, e_win_q, e_round_q;
	logic        entry_in_q;
	logic [63:0] mstart_q;
	logic [63:0] mend_q;
	logic [52:0] pages_q;
	logic [3:0]  fcode_q;
	logic        hit_q;

	// result register
	logic        out_valid_q;
	logic        is_load_o_q, seg_ok_o_q, wr_o_q, ex_o_q;
	logic        done_o_q, img_ok_o_q, entry_ok_o_q;
	logic [3:0]  code_o_q;
	logic [63:0] mstart_o_q;
	logic [52:0] pages_o_q;

	logic             accept;
	logic             commit;
	logic [63:0]      al_m1;
	logic             big_al;
	logic [64:0]      round_sum;
	logic [63:0]      span;
	logic [3:0]       fcode;
	logic             launch;
	logic [3:0]       code;
	logic             seg_ok;
	logic             img_ok;
	logic             full;
	elsc_pkg::query_t chain [MAX_SEGMENTS+1];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || done_q;
	assign commit   = done_q && (!out_valid_q || !out_stall);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			entry_address_q <= '0;
			user_base_q     <= '0;
			user_limit_q    <= '0;
			decl_count_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				elsc_pkg::REG_IMAGE_SIZE:    image_size_q    <= cfg_data;
				elsc_pkg::REG_ENTRY_ADDRESS: entry_address_q <= cfg_data;
				elsc_pkg::REG_USER_BASE:     user_base_q     <= cfg_data;
				elsc_pkg::REG_USER_LIMIT:    user_limit_q    <= cfg_data;
				elsc_pkg::REG_DECL_COUNT:    decl_count_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// ---------------- check datapath ----------------
	assign al_m1     = al_q - 64'd1;
	assign big_al    = al_q > 64'd1;
	assign round_sum = {1'b0, memend_q[63:0] & ~PAGE_MASK}
		+ ((|(memend_q[63:0] & PAGE_MASK)) ? {1'b0, PAGE_SIZE} : 65'd0);
	assign span      = mend_q - mstart_q;

	always_comb begin
		if (e_fsz_q)                      fcode = elsc_pkg::ERR_FILE_SIZE;
		else if (fend_q[64])              fcode = elsc_pkg::ERR_FILE_OVF;
		else if (e_img_q)                 fcode = elsc_pkg::ERR_FILE_END;
		else if (memend_q[64])            fcode = elsc_pkg::ERR_MEM_OVF;
		else if (e_mzero_q)               fcode = elsc_pkg::ERR_MEM_ZERO;
		else if (e_win_q)                 fcode = elsc_pkg::ERR_WINDOW;
		else if (e_pow2_q)                fcode = elsc_pkg::ERR_ALIGN_POW2;
		else if (e_mod_q)                 fcode = elsc_pkg::ERR_ALIGN_MOD;
		else if (wr_q && ex_q)            fcode = elsc_pkg::ERR_WRITE_EXEC;
		else if (e_round_q)               fcode = elsc_pkg::ERR_ROUND_OVF;
		else if (mend_q <= mstart_q)      fcode = elsc_pkg::ERR_EMPTY;
		else                              fcode = elsc_pkg::ERR_OK;
	end

	assign launch = (state_q == ST_CHK3) && is_load_q && (fcode == elsc_pkg::ERR_OK);

	always_ff @(posedge clk) begin
		if (accept) begin
			is_load_q <= (header_type == elsc_pkg::PT_LOAD);
			ex_q      <= header_flags[0];
			wr_q      <= header_flags[1];
			last_q    <= last_header;
			off_q     <= offset_in_file;
			va_q      <= virt_addr;
			fsz_q     <= bytes_in_file;
			msz_q     <= bytes_in_memory;
			al_q      <= align_value;
		end
		if (state_q == ST_CHK1) begin
			fend_q    <= {1'b0, off_q} + {1'b0, fsz_q};
			memend_q  <= {1'b0, va_q} + {1'b0, msz_q};
			e_fsz_q   <= fsz_q > msz_q;
			e_mzero_q <= msz_q == 64'd0;
			e_base_q  <= va_q < user_base_q;
			e_pow2_q  <= big_al && (|(al_q & al_m1));
			e_mod_q   <= big_al && (|((va_q ^ off_q) & al_m1));
		end
		if (state_q == ST_CHK2) begin
			e_img_q    <= fend_q[63:0] > image_size_q;
			e_win_q    <= e_base_q || (memend_q[63:0] > user_limit_q);
			e_round_q  <= round_sum[64];
			mend_q     <= round_sum[63:0];
			mstart_q   <= va_q & ~PAGE_MASK;
			entry_in_q <= (entry_address_q >= va_q) && (entry_address_q < memend_q[63:0]);
		end
		if (state_q == ST_CHK3) begin
			fcode_q <= fcode;
			pages_q <= 53'(span >> PAGE_SHIFT);
			hit_q   <= 1'b0;
		end else if (state_q == ST_WALK && chain[MAX_SEGMENTS].valid) begin
			hit_q <= chain[MAX_SEGMENTS].hit;
		end
	end

	// ---------------- range cells ----------------
	assign chain[0] = {launch, 1'b0, mstart_q, mend_q};

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		elsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.occupied (count_q > CNT_W'(i)),
			.wr_en    (commit && seg_ok && (count_q == CNT_W'(i))),
			.wr_start (mstart_q),
			.wr_end   (mend_q),
			.q_in     (chain[i]),
			.q_out    (chain[i+1])
		);
	end

	// ---------------- sequencing ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CHK1;
				ST_CHK1: state_q <= ST_CHK2;
				ST_CHK2: state_q <= ST_CHK3;
				ST_CHK3: begin
					if (launch) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_WALK: begin
					if (chain[MAX_SEGMENTS].valid) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				done_q <= 1'b0;
			end
		end
	end

	// ---------------- result and image state ----------------
	assign full = count_q >= CNT_W'(MAX_SEGMENTS);

	always_comb begin
		if (!is_load_q)                     code = elsc_pkg::ERR_SKIPPED;
		else if (fcode_q != elsc_pkg::ERR_OK) code = fcode_q;
		else if (hit_q)                     code = elsc_pkg::ERR_OVERLAP;
		else if (full)                      code = elsc_pkg::ERR_TOO_MANY;
		else                                code = elsc_pkg::ERR_OK;
	end

	assign seg_ok = is_load_q && (code == elsc_pkg::ERR_OK);
	// The failure of this item counts towards the verdict of its own image.
	assign img_ok = !(failed_q || (is_load_q && !seg_ok)) && (decl_count_q != 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			failed_q    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					count_q  <= '0;
					failed_q <= 1'b0;
					found_q  <= 1'b0;
				end else begin
					if (seg_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (is_load_q && !seg_ok) begin
						failed_q <= 1'b1;
					end
					if (seg_ok && ex_q && entry_in_q) begin
						found_q <= 1'b1;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			is_load_o_q  <= is_load_q;
			seg_ok_o_q   <= seg_ok;
			code_o_q     <= code;
			mstart_o_q   <= seg_ok ? mstart_q : 64'd0;
			pages_o_q    <= seg_ok ? pages_q : 53'd0;
			wr_o_q       <= seg_ok && wr_q;
			ex_o_q       <= seg_ok && ex_q;
			done_o_q     <= last_q;
			img_ok_o_q   <= last_q && img_ok;
			entry_ok_o_q <= last_q && img_ok && (found_q || (seg_ok && ex_q && entry_in_q));
		end
	end

	assign out_valid  = out_valid_q;
	assign is_load    = is_load_o_q;
	assign segment_ok = seg_ok_o_q;
	assign error_code = code_o_q;
	assign map_base   = mstart_o_q;
	assign map_pages  = pages_o_q;
	assign writable   = wr_o_q;
	assign executable = ex_o_q;
	assign image_done = done_o_q;
	assign image_ok   = img_ok_o_q;
	assign entry_ok   = entry_ok_o_q;

endmodule

/* hdl/elsc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsc_cell
// One stored mapping; tests a passing query for overlap and hands it on.
// ----------------------------------------------------------------------------
module elsc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 occupied,
	input  logic                 wr_en,
	input  logic [63:0]          wr_start,
	input  logic [63:0]          wr_end,
	input  elsc_pkg::query_t     q_in,
	output elsc_pkg::query_t     q_out
);

	logic [63:0]      start_q;
	logic [63:0]      end_q;
	logic             valid_q;
	elsc_pkg::query_t pay_q;
	logic             overlap;

	assign overlap = occupied && (start_q < q_in.map_end) && (q_in.map_start < end_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= wr_start;
			end_q   <= wr_end;
		end
		pay_q.valid     <= 1'b0;
		pay_q.hit       <= q_in.hit | overlap;
		pay_q.map_start <= q_in.map_start;
		pay_q.map_end   <= q_in.map_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= q_in.valid;
		end
	end

	always_comb begin
		q_out       = pay_q;
		q_out.valid = valid_q;
	end

endmodule

/* tb/elsc_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsc_result_checker
// Watches the configuration port and both handshake channels of the load
// segment checker. It keeps its own copy of the stored mappings, works out
// the result of every accepted header and compares each returned result,
// field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module elsc_result_checker #(
	parameter int PAGE_SHIFT   = 12,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [elsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [31:0]                    header_type,
	input  logic [31:0]                    header_flags,
	input  logic [63:0]                    offset_in_file,
	input  logic [63:0]                    virt_addr,
	input  logic [63:0]                    bytes_in_file,
	input  logic [63:0]                    bytes_in_memory,
	input  logic [63:0]                    align_value,
	input  logic                           last_header,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           is_load,
	input  logic                           segment_ok,
	input  logic [3:0]                     error_code,
	input  logic [63:0]                    map_base,
	input  logic [52:0]                    map_pages,
	input  logic                           writable,
	input  logic                           executable,
	input  logic                           image_done,
	input  logic                           image_ok,
	input  logic                           entry_ok,
	output int                             mismatches,
	output int                             outstanding
);

	localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
	localparam logic [63:0] PAGE_MASK  = PAGE_BYTES - 64'd1;

	typedef struct packed {
		logic        is_load;
		logic        segment_ok;
		logic [3:0]  error_code;
		logic [63:0] map_base;
		logic [52:0] map_pages;
		logic        writable;
		logic        executable;
		logic        image_done;
		logic        image_ok;
		logic        entry_ok;
	} seg_result_t;

	logic [63:0] size_cfg, entry_cfg, base_cfg, limit_cfg;
	logic [4:0]  decl_cfg;
	logic [63:0] map_lo [MAX_SEGMENTS];
	logic [63:0] map_hi [MAX_SEGMENTS];
	int          maps_held;
	logic        image_bad, entry_seen;
	seg_result_t expected_q [$];
	seg_result_t want;

	// Field checks in their fixed order; the first one that fails gives the code.
	function automatic logic [3:0] field_fault(
		input  logic [31:0] flags,
		input  logic [63:0] off, va, fsz, msz, al,
		output logic [63:0] mstart, mend,
		output logic        wr, ex
	);
		logic [64:0] fend, memend, rounded;
		logic [63:0] rem;
		mstart = '0;
		mend = '0;
		wr = 1'b0;
		ex = 1'b0;
		fend = {1'b0, off} + {1'b0, fsz};
		memend = {1'b0, va} + {1'b0, msz};
		if (fsz > msz) return elsc_pkg::ERR_FILE_SIZE;
		if (fend[64]) return elsc_pkg::ERR_FILE_OVF;
		if (fend[63:0] > size_cfg) return elsc_pkg::ERR_FILE_END;
		if (memend[64]) return elsc_pkg::ERR_MEM_OVF;
		if (msz == '0) return elsc_pkg::ERR_MEM_ZERO;
		if (va < base_cfg || memend[63:0] > limit_cfg) return elsc_pkg::ERR_WINDOW;
		if (al > 64'd1) begin
			if ((al & (al - 64'd1)) != '0) return elsc_pkg::ERR_ALIGN_POW2;
			if ((va & (al - 64'd1)) != (off & (al - 64'd1))) return elsc_pkg::ERR_ALIGN_MOD;
		end
		wr = flags[1];
		ex = flags[0];
		if (wr && ex) return elsc_pkg::ERR_WRITE_EXEC;
		mstart = va & ~PAGE_MASK;
		rem = memend[63:0] & PAGE_MASK;
		rounded = (rem == '0) ? memend : memend + {1'b0, PAGE_BYTES - rem};
		if (rounded[64]) return elsc_pkg::ERR_ROUND_OVF;
		mend = rounded[63:0];
		if (mend <= mstart || ((mend - mstart) >> PAGE_SHIFT) == '0)
			return elsc_pkg::ERR_EMPTY;
		return elsc_pkg::ERR_OK;
	endfunction

	// Result of one header; updates the mapping store and the image flags.
	function automatic seg_result_t judge_header(
		input logic [31:0] htype, flags,
		input logic [63:0] off, va, fsz, msz, al,
		input logic        lst
	);
		seg_result_t r;
		logic [63:0] mstart, mend, span;
		logic        wr, ex, ok, hit;
		logic [3:0]  code;
		r = '0;
		ok = 1'b0;
		hit = 1'b0;
		code = elsc_pkg::ERR_SKIPPED;
		mstart = '0;
		mend = '0;
		wr = 1'b0;
		ex = 1'b0;
		if (htype == elsc_pkg::PT_LOAD) begin
			code = field_fault(flags, off, va, fsz, msz, al, mstart, mend, wr, ex);
			if (code == elsc_pkg::ERR_OK) begin
				for (int i = 0; i < maps_held; i++)
					if (map_lo[i] < mend && mstart < map_hi[i])
						hit = 1'b1;
				if (hit)
					code = elsc_pkg::ERR_OVERLAP;
				else if (maps_held >= MAX_SEGMENTS)
					code = elsc_pkg::ERR_TOO_MANY;
			end
			if (code == elsc_pkg::ERR_OK) begin
				ok = 1'b1;
				map_lo[maps_held] = mstart;
				map_hi[maps_held] = mend;
				maps_held++;
				if (ex && entry_cfg >= va && entry_cfg < va + msz)
					entry_seen = 1'b1;
			end else begin
				image_bad = 1'b1;
			end
		end
		r.is_load = (htype == elsc_pkg::PT_LOAD);
		r.segment_ok = ok;
		r.error_code = code;
		if (ok) begin
			span = (mend - mstart) >> PAGE_SHIFT;
			r.map_base = mstart;
			r.map_pages = span[52:0];
			r.writable = wr;
			r.executable = ex;
		end
		if (lst) begin
			r.image_done = 1'b1;
			r.image_ok = !image_bad && decl_cfg != '0;
			r.entry_ok = r.image_ok && entry_seen;
			maps_held = 0;
			image_bad = 1'b0;
			entry_seen = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg = '0;
			entry_cfg = '0;
			base_cfg = '0;
			limit_cfg = '0;
			decl_cfg = '0;
			maps_held = 0;
			image_bad = 1'b0;
			entry_seen = 1'b0;
			expected_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// The result side is looked at first, so that an item accepted at
			// this edge can never be matched against a result of the same edge.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t result: expected none, actual error_code %0h",
						$time, error_code);
				end else begin
					want = expected_q.pop_front();
					check_field("is_load", want.is_load, is_load);
					check_field("segment_ok", want.segment_ok, segment_ok);
					check_field("error_code", want.error_code, error_code);
					check_field("map_base", want.map_base, map_base);
					check_field("map_pages", want.map_pages, map_pages);
					check_field("writable", want.writable, writable);
					check_field("executable", want.executable, executable);
					check_field("image_done", want.image_done, image_done);
					check_field("image_ok", want.image_ok, image_ok);
					check_field("entry_ok", want.entry_ok, entry_ok);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(judge_header(header_type, header_flags,
					offset_in_file, virt_addr, bytes_in_file, bytes_in_memory,
					align_value, last_header));
			if (cfg_we) begin
				case (cfg_index)
					elsc_pkg::REG_IMAGE_SIZE:    size_cfg = cfg_data;
					elsc_pkg::REG_ENTRY_ADDRESS: entry_cfg = cfg_data;
					elsc_pkg::REG_USER_BASE:     base_cfg = cfg_data;
					elsc_pkg::REG_USER_LIMIT:    limit_cfg = cfg_data;
					elsc_pkg::REG_DECL_COUNT:    decl_cfg = cfg_data[4:0];
					default: ;
				endcase
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

/* tb/tb_elf_load_segment_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elf_load_segment_checker_unit
// Drives program headers into the load segment checker: a short directed
// run over most fault codes, then phases of random register settings, each
// followed by images built mostly from well-placed load segments with some
// skipped, faulty and random headers mixed in. Results are checked by the
// result checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_elf_load_segment_checker_unit;

	localparam int          PAGE_SHIFT   = 12;
	localparam int          MAX_SEGMENTS = 16;
	localparam int          IDX_W        = elsc_pkg::CFG_IDX_W;
	localparam logic [63:0] PAGE_MASK    = (64'd1 << PAGE_SHIFT) - 64'd1;
	localparam int          ITEM_TARGET  = 1100;
	localparam int          QUIET_FROM   = 950;
	localparam int          SETTLE       = MAX_SEGMENTS + 8;
	localparam int          CYCLE_LIMIT  = 600000;

	typedef struct {
		logic [31:0] htype;
		logic [31:0] flags;
		logic [63:0] off;
		logic [63:0] va;
		logic [63:0] fsz;
		logic [63:0] msz;
		logic [63:0] align;
		logic        last;
	} hdr_t;

	typedef enum int {
		BAD_FILE_SIZE, BAD_FILE_OVF, BAD_FILE_END, BAD_MEM_OVF, BAD_MEM_ZERO,
		BAD_WINDOW, BAD_ALIGN_POW2, BAD_ALIGN_MOD, BAD_WRITE_EXEC, BAD_OVERLAP,
		BAD_NOISE, BAD_ROUND_UP
	} fault_kind_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [63:0]      cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [31:0]      header_type;
	logic [31:0]      header_flags;
	logic [63:0]      offset_in_file;
	logic [63:0]      virt_addr;
	logic [63:0]      bytes_in_file;
	logic [63:0]      bytes_in_memory;
	logic [63:0]      align_value;
	logic             last_header;
	logic             out_valid;
	logic             out_stall;
	logic             is_load;
	logic             segment_ok;
	logic [3:0]       error_code;
	logic [63:0]      map_base;
	logic [52:0]      map_pages;
	logic             writable;
	logic             executable;
	logic             image_done;
	logic             image_ok;
	logic             entry_ok;
	int               mismatches;
	int               outstanding;

	int               sent;
	int               gap_pct;
	int               stall_pct;
	logic [63:0]      size_cfg, base_cfg, limit_cfg;

	elf_load_segment_checker_unit #(
		.PAGE_SHIFT  (PAGE_SHIFT),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_dut (.*);

	elsc_result_checker #(
		.PAGE_SHIFT  (PAGE_SHIFT),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: stall bursts at the rate of the current phase.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic hdr_t make_hdr(input logic [31:0] t, fl,
		input logic [63:0] o, v, fs, ms, al, input logic lst);
		hdr_t h;
		h.htype = t;
		h.flags = fl;
		h.off = o;
		h.va = v;
		h.fsz = fs;
		h.msz = ms;
		h.align = al;
		h.last = lst;
		return h;
	endfunction

	task automatic send_header(input hdr_t h);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		header_type <= h.htype;
		header_flags <= h.flags;
		offset_in_file <= h.off;
		virt_addr <= h.va;
		bytes_in_file <= h.fsz;
		bytes_in_memory <= h.msz;
		align_value <= h.align;
		last_header <= h.last;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Stops the sender and waits until every expected result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [63:0] img, entry, base, limit,
		input logic [4:0] count);
		size_cfg = img;
		base_cfg = base;
		limit_cfg = limit;
		put_reg(elsc_pkg::REG_IMAGE_SIZE, img);
		put_reg(elsc_pkg::REG_ENTRY_ADDRESS, entry);
		put_reg(elsc_pkg::REG_USER_BASE, base);
		put_reg(elsc_pkg::REG_USER_LIMIT, limit);
		put_reg(elsc_pkg::REG_DECL_COUNT, {59'd0, count});
		// An index past the last register must leave everything unchanged.
		if ($urandom_range(0, 3) == 0)
			put_reg(IDX_W'($urandom_range(elsc_pkg::REG_DECL_COUNT + 1, 2 ** IDX_W - 1)),
				{$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	task automatic pick_settings();
		logic [63:0] base;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			base = {20'd0, 32'($urandom), 12'd0};
			load_settings(64'h1_0000_0000 + $urandom, base + $urandom_range(0, 'h3000),
				base, base + (64'd1 << 28), 5'($urandom_range(1, MAX_SEGMENTS)));
		end else if (kind < 8) begin
			load_settings('1, $urandom_range(0, 1) ? '0 : 64'($urandom_range(0, 'h3000)),
				'0, '1, $urandom_range(0, 1) ? 5'(MAX_SEGMENTS) : 5'd0);
		end else if (kind == 8) begin
			load_settings('0, '1, '0, '0, '0);
		end else begin
			base = {$urandom, $urandom};
			load_settings({$urandom, $urandom}, base + $urandom_range(0, 'h3000),
				base, '1, 5'($urandom_range(0, MAX_SEGMENTS)));
		end
	endtask

	// A load segment placed at or just after spot, inside the window.
	function automatic hdr_t shape_segment(input logic [63:0] spot);
		hdr_t h;
		logic [63:0] mask;
		int k;
		h.htype = elsc_pkg::PT_LOAD;
		h.flags = $urandom;
		h.flags[1:0] = 2'($urandom_range(0, 2));  // never write and execute together
		h.va = ($urandom_range(0, 3) == 0) ? spot
			: spot + 64'($urandom_range(0, 32'(PAGE_MASK)));
		h.msz = 64'($urandom_range(1, 3 << PAGE_SHIFT));
		h.fsz = $urandom_range(0, 1) ? h.msz : 64'($urandom_range(0, 32'(h.msz)));
		k = $urandom_range(0, 14);
		h.align = (k == 0) ? '0 : 64'd1 << (k - 1);
		mask = (h.align > 64'd1) ? h.align - 64'd1 : '0;
		h.off = (64'($urandom_range(0, 1 << 20)) & ~mask) | (h.va & mask);
		h.last = 1'b0;
		return h;
	endfunction

	task automatic spoil_segment(inout hdr_t h, input hdr_t good, input bit have_good);
		fault_kind_t kind;
		kind = fault_kind_t'($urandom_range(0, BAD_ROUND_UP));
		case (kind)
			BAD_FILE_SIZE: h.fsz = h.msz + $urandom_range(1, 100);
			BAD_FILE_OVF: begin
				h.off = '1 - $urandom_range(0, 2);
				h.fsz = h.msz;
			end
			BAD_FILE_END: h.off = size_cfg - h.fsz + $urandom_range(1, 16);
			BAD_MEM_OVF: begin
				h.va = '1 - $urandom_range(0, 255);
				h.msz = 64'h1000 + $urandom_range(0, 'hFFFF);
				h.fsz = '0;
				h.off = '0;
			end
			BAD_MEM_ZERO: begin
				h.msz = '0;
				h.fsz = '0;
			end
			BAD_WINDOW: h.va = $urandom_range(0, 1) ? base_cfg - $urandom_range(1, 4096)
				: limit_cfg - $urandom_range(0, 15);
			BAD_ALIGN_POW2: h.align = {$urandom, $urandom} | 64'd3;
			BAD_ALIGN_MOD: begin
				h.align = 64'd1 << $urandom_range(1, PAGE_SHIFT);
				h.off = (h.off & ~(h.align - 64'd1)) | ((h.va ^ 64'd1) & (h.align - 64'd1));
			end
			BAD_WRITE_EXEC: h.flags[1:0] = 2'b11;
			BAD_OVERLAP: if (have_good) h = good;
			BAD_NOISE: begin
				h.htype = $urandom;
				h.flags = $urandom;
				h.off = {$urandom, $urandom};
				h.va = {$urandom, $urandom};
				h.fsz = {$urandom, $urandom};
				h.msz = {$urandom, $urandom};
				h.align = {$urandom, $urandom};
			end
			default: begin
				// The top page cannot be rounded up without wrapping.
				h.va = 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(1, 'hFFE));
				h.msz = 64'($urandom_range(1, 32'(~h.va)));
				h.fsz = '0;
				h.off = '0;
				h.align = '0;
			end
		endcase
	endtask

	task automatic send_image();
		hdr_t h, good;
		logic [63:0] spot;
		int n, good_pct;
		bit have_good;
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_SEGMENTS + 1, MAX_SEGMENTS + 4)
			: $urandom_range(1, 8);
		// Long images are mostly clean so that the store actually fills up.
		good_pct = (n > MAX_SEGMENTS) ? 97 : 75;
		spot = (base_cfg + PAGE_MASK) & ~PAGE_MASK;
		have_good = 1'b0;
		good = shape_segment(spot);
		for (int k = 0; k < n; k++) begin
			h = shape_segment(spot);
			if ($urandom_range(0, 99) < good_pct) begin
				good = h;
				have_good = 1'b1;
				spot = ((h.va + h.msz + PAGE_MASK) & ~PAGE_MASK)
					+ (64'($urandom_range(0, 3)) << PAGE_SHIFT);
			end else if ($urandom_range(0, 2) == 0) begin
				h.htype = $urandom_range(0, 1) ? $urandom : $urandom_range(2, 7);
				if (h.htype == elsc_pkg::PT_LOAD)
					h.htype = '0;
			end else begin
				spoil_segment(h, good, have_good);
			end
			h.last = (k == n - 1);
			send_header(h);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		header_type <= '0;
		header_flags <= '0;
		offset_in_file <= '0;
		virt_addr <= '0;
		bytes_in_file <= '0;
		bytes_in_memory <= '0;
		align_value <= '0;
		last_header <= 1'b0;
		sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a header per fault code but EMPTY and TOO_MANY, then two clean images.
		load_settings(64'h8000_0000_0000_0000, 64'h1000_0010, 64'h1000, '1,
			5'(MAX_SEGMENTS));
		send_header(make_hdr('0, '0, '0, '0, '0, '0, '0, 1'b0));
		send_header(make_hdr('1, '1, '1, '1, '1, '1, '1, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, 64'h10000, 64'h20, 64'h10, '0,
			1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '1, 64'h10000, 64'd1, 64'd1, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, 64'h8000_0000_0000_0000, 64'h10000,
			64'd1, 64'h10, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, '1, '0, 64'd2, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, 64'h10000, '0, '0, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, '0, '0, 64'h10, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, 64'h10000, '0, 64'h10, 64'd3,
			1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, 64'h20, 64'h1000_0010, '0, 64'h10,
			64'h1000, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, 32'd3, '0, 64'h10000, '0, 64'h10, '0,
			1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, 64'hFFFF_FFFF_FFFF_F010, '0,
			64'hFE0, '0, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, 32'd1, 64'h10, 64'h1000_0010, 64'h100,
			64'h2000, 64'h1000, 1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, 32'd2, '0, 64'h1000_1000, '0, 64'h10, '0,
			1'b0));
		send_header(make_hdr(elsc_pkg::PT_LOAD, 32'hFFFF_FFFE, '0, 64'h2000_0000, '0,
			64'h1000, 64'd1, 1'b0));
		send_header(make_hdr(32'd2, '0, '0, '0, '0, '0, '0, 1'b1));
		send_header(make_hdr(elsc_pkg::PT_LOAD, 32'd1, '0, 64'h1000_0000, '0, 64'h100, '0,
			1'b1));
		send_header(make_hdr(elsc_pkg::PT_LOAD, '0, '0, 64'h3000_0000, '0, 64'h100, '0,
			1'b1));
		drain_results();

		while (sent < ITEM_TARGET) begin
			pick_settings();
			if (sent >= QUIET_FROM) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(0, 2) * 20;
				stall_pct = $urandom_range(0, 2) * 20;
			end
			repeat ($urandom_range(2, 6)) send_image();
			drain_results();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
